/* rtl/pisc_pkg.sv */
`default_nettype none
package pisc_pkg;
  localparam int NUM_CHANNELS = 2;
  localparam int CH_W = 1;
  localparam int ACC_W = 48;
  localparam int PRD_W = 64;
  localparam int CNT_W = 6;

  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [2:0] REG_DRIVE_MAX  = 3'd2;
  localparam logic [2:0] REG_DRIVE_MIN  = 3'd3;
  localparam logic [2:0] REG_MAX_TICKS  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTEG,
    ST_SAT,
    ST_PROD,
    ST_SUM,
    ST_OUT
  } pisc_state_t;
endpackage
`default_nettype wire

/* rtl/pi_speed_controller_antiwindup_unit.sv */
// A stored-drive read returns the held drive with no arithmetic; an update runs
// 16 shift-add steps for error*ticks, a saturation step, 16 shift-add steps for
// error*prop_gain and integral*integ_gain in parallel, and one sum/clamp step
// (integration held cuts the error*ticks steps short). One request at a time: a
// new one is taken only after the last result leaves, so output stalls hold input.
// Reset (rst_n low, synchronous) loads the default gains and limits and clears
// both channels' integral and drive.
`default_nettype none
module pi_speed_controller_antiwindup_unit
  import pisc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: [0] chan, [1] new_sample, [17:2] target_speed,
  // [33:18] measured_speed, [49:34] elapsed_ticks, [55:50] zero
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: [15:0] drive, [16] updated, [23:17] zero
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // configuration
  logic [15:0] prop_gain_r, integ_gain_r, max_ticks_r;
  logic signed [15:0] drive_max_r, drive_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= 16'd4915;
      integ_gain_r <= 16'd53687;
      drive_max_r  <= 16'sd16384;
      drive_min_r  <= -16'sd13107;
      max_ticks_r  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
        REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
        REG_DRIVE_MAX:  drive_max_r  <= cfg_wdata;
        REG_DRIVE_MIN:  drive_min_r  <= cfg_wdata;
        REG_MAX_TICKS:  max_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-channel state, reset clears both
  logic signed [ACC_W-1:0] integ_r [NUM_CHANNELS];
  logic signed [15:0]      drv_r   [NUM_CHANNELS];

  pisc_state_t state_r, state_nxt;

  logic [CH_W-1:0]    ch_r;
  logic signed [16:0] err_r;        // Q9.8 error, 17 bits
  logic [15:0]        ticks_r;      // capped tick count, shifted out LSB first
  logic [15:0]        pgain_r;      // shifted out LSB first
  logic [15:0]        igain_r;
  logic signed [ACC_W+1:0] acc_r;   // integral under construction
  logic signed [ACC_W+1:0] madd_r;  // shifted multiplicand for error*ticks
  logic signed [PRD_W-1:0] pp_r;    // error*prop_gain
  logic signed [PRD_W-1:0] ip_r;    // integral*integ_gain
  logic signed [PRD_W-1:0] pm_r;    // shifted error
  logic signed [PRD_W-1:0] im_r;    // shifted integral
  logic [CNT_W-1:0]   cnt_r;
  logic               upd_r;
  logic [15:0]        res_r;
  logic               ov_r;

  logic               prev_in;
  logic signed [15:0] prev_drv;
  logic signed [17:0] sum_hi;
  logic signed [PRD_W-1:0] dsum;
  logic signed [15:0] clamp;

  assign in_tready = (state_r == ST_IDLE);
  assign out_tdata = {7'd0, upd_r, res_r};

  // previous drive strictly inside limits enables integration
  assign prev_drv = drv_r[ch_r];
  assign prev_in  = (prev_drv < drive_max_r) && (prev_drv > drive_min_r);

  assign dsum = (pp_r >>> 8) + (ip_r >>> 24);
  assign sum_hi = dsum[17:0];

  always_comb begin
    if (dsum < PRD_W'(drive_min_r))       clamp = drive_min_r;
    else if (dsum > PRD_W'(drive_max_r))  clamp = drive_max_r;
    else                                  clamp = sum_hi[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = in_tdata[1] ? ST_INTEG : ST_OUT;
      ST_INTEG: if (!prev_in || cnt_r == CNT_W'(15)) state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_PROD;
      ST_PROD:  if (cnt_r == CNT_W'(15)) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign out_tvalid = (state_r == ST_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        integ_r[i] <= '0;
        drv_r[i]   <= '0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            ch_r    <= in_tdata[0];
            upd_r   <= in_tdata[1];
            res_r   <= drv_r[in_tdata[0]];
            err_r   <= 17'(signed'(in_tdata[17:2])) - 17'(signed'(in_tdata[33:18]));
            ticks_r <= (in_tdata[49:34] > max_ticks_r) ? max_ticks_r : in_tdata[49:34];
            cnt_r   <= '0;
          end
        end
        ST_INTEG: begin
          if (cnt_r == '0) begin
            acc_r  <= (ACC_W+2)'(integ_r[ch_r]) + (ticks_r[0] ? (ACC_W+2)'(err_r) : '0);
            madd_r <= (ACC_W+2)'(err_r) <<< 1;
          end else begin
            if (ticks_r[0]) acc_r <= acc_r + madd_r;
            madd_r <= madd_r <<< 1;
          end
          ticks_r <= ticks_r >> 1;
          cnt_r   <= cnt_r + 1'b1;
          ov_r    <= prev_in;
        end
        ST_SAT: begin
          if (ov_r) begin
            if (acc_r > (ACC_W+2)'(48'sh7FFF_FFFF_FFFF))
              acc_r <= (ACC_W+2)'(48'sh7FFF_FFFF_FFFF);
            else if (acc_r < -((ACC_W+2)'(48'sh7FFF_FFFF_FFFF)) - 1)
              acc_r <= -((ACC_W+2)'(48'sh7FFF_FFFF_FFFF)) - 1;
          end else begin
            acc_r <= (ACC_W+2)'(integ_r[ch_r]);
          end
          pgain_r <= prop_gain_r;
          igain_r <= integ_gain_r;
          pp_r    <= '0;
          ip_r    <= '0;
          pm_r    <= PRD_W'(err_r);
          cnt_r   <= '0;
        end
        ST_PROD: begin
          if (cnt_r == '0) begin
            integ_r[ch_r] <= acc_r[ACC_W-1:0];
            // acc_r is already within 48-bit range; sign-extend the whole value
            im_r <= PRD_W'(acc_r) <<< 1;
            if (igain_r[0]) ip_r <= PRD_W'(acc_r);
          end else begin
            if (igain_r[0]) ip_r <= ip_r + im_r;
            im_r <= im_r <<< 1;
          end
          if (pgain_r[0]) pp_r <= pp_r + pm_r;
          pm_r    <= pm_r <<< 1;
          pgain_r <= pgain_r >> 1;
          igain_r <= igain_r >> 1;
          cnt_r   <= cnt_r + 1'b1;
        end
        ST_SUM: begin
          res_r       <= clamp;
          drv_r[ch_r] <= clamp;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/sv/pi_speed_controller_antiwindup_unit_tb.sv */
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard for the regulator: holds its own copy of gains, limits and
// per-channel integral/drive, predicts each accepted request, checks results.
class pisc_scoreboard;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  bit [15:0]       prop_gain, integ_gain, max_ticks;
  logic signed [15:0] drive_max, drive_min;
  longint          integral[2];
  int              drive_held[2];
  logic [16:0]     expected_q[$];
  int              errors, checked, updates, clamps;

  function void reset_state();
    prop_gain = 16'd4915; integ_gain = 16'd53687;
    drive_max = 16'sd16384; drive_min = -16'sd13107; max_ticks = 16'd1000;
    foreach (integral[i]) begin
      integral[i] = 0; drive_held[i] = 0;
    end
    expected_q.delete();
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      pisc_pkg::REG_PROP_GAIN:  prop_gain = val;
      pisc_pkg::REG_INTEG_GAIN: integ_gain = val;
      pisc_pkg::REG_DRIVE_MAX:  drive_max = val;
      pisc_pkg::REG_DRIVE_MIN:  drive_min = val;
      pisc_pkg::REG_MAX_TICKS:  max_ticks = val;
      default: ;
    endcase
  endfunction

  // Note an accepted request and queue the drive it must produce.
  function void note_request(logic [55:0] d);
    int      ch, ticks, prev, lo, hi;
    longint  err, acc, drv;
    ch = int'(d[0]);
    if (!d[1]) begin
      expected_q.push_back({1'b0, drive_held[ch][15:0]});
      return;
    end
    ticks = int'(d[49:34]);
    if (ticks > int'(max_ticks)) ticks = int'(max_ticks);
    err = longint'($signed(d[17:2])) - longint'($signed(d[33:18]));
    lo = int'(drive_min); hi = int'(drive_max);
    prev = drive_held[ch];
    acc = integral[ch];
    if (prev < hi && prev > lo) begin
      acc += err * ticks;
      if (acc > ACC_HI) acc = ACC_HI;
      else if (acc < ACC_LO) acc = ACC_LO;
      integral[ch] = acc;
    end
    // >>> on signed longint floors; acc*gain fits in 64 bits (47+16 bits)
    drv = ((err * longint'(prop_gain)) >>> 8) + ((acc * longint'(integ_gain)) >>> 24);
    if (drv < lo) begin
      drv = lo; clamps++;
    end else if (drv > hi) begin
      drv = hi; clamps++;
    end
    drive_held[ch] = int'(drv);
    updates++;
    expected_q.push_back({1'b1, drv[15:0]});
  endfunction

  function void check_result(logic [23:0] d);
    logic [16:0] exp_v;
    checked++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result drive=%0d updated=%0b", $time,
               $signed(d[15:0]), d[16]);
      errors++;
      return;
    end
    exp_v = expected_q.pop_front();
    if (d[15:0] !== exp_v[15:0]) begin
      $display("%0t: drive mismatch expected %0d actual %0d", $time,
               $signed(exp_v[15:0]), $signed(d[15:0]));
      errors++;
    end
    if (d[16] !== exp_v[16]) begin
      $display("%0t: updated mismatch expected %0b actual %0b", $time, exp_v[16], d[16]);
      errors++;
    end
    if (d[23:17] !== 7'd0) begin
      $display("%0t: pad bits expected 0 actual %h", $time, d[23:17]);
      errors++;
    end
  endfunction
endclass

module pi_speed_controller_antiwindup_unit_tb;
  import pisc_pkg::*;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  // tdata: [0] chan, [1] new_sample, [17:2] target_speed,
  // [33:18] measured_speed, [49:34] elapsed_ticks, [55:50] zero
  logic [55:0] in_tdata;
  logic        out_tvalid, out_tready;
  // tdata: [15:0] drive, [16] updated, [23:17] zero
  logic [23:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  pisc_scoreboard sb;
  bit             no_idle;    // long stretch with no bubbles on either side
  int             requests_sent;

  pi_speed_controller_antiwindup_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .cfg_we, .cfg_index, .cfg_wdata
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: bounds the slowest run of ~1220 requests plus stalls.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random backpressure (none while no_idle is set), check every accepted result.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  // Drive one request; random idle cycles in front of it unless no_idle is set.
  task automatic send_request(bit ch, bit fresh, logic [15:0] tgt, logic [15:0] meas,
                              logic [15:0] ticks);
    while (!no_idle && $urandom_range(99) < 35) begin
      @(posedge clk);
      in_tvalid <= 1'b0;
    end
    @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, ticks, meas, tgt, fresh, ch};
    do @(posedge clk); while (!in_tready);
    sb.note_request(in_tdata);
    requests_sent++;
    in_tvalid <= 1'b0;
  endtask

  task automatic send_random();
    logic [15:0] tgt, meas, ticks;
    tgt = 16'($urandom);
    // mostly realistic errors near the setpoint, sometimes anything
    meas = ($urandom_range(3) == 0) ? 16'($urandom) : tgt + 16'($urandom_range(1023)) - 16'd512;
    case ($urandom_range(3))
      0: ticks = 16'($urandom);
      1: ticks = 16'($urandom_range(2000));
      default: ticks = 16'($urandom_range(20));
    endcase
    send_request(1'($urandom_range(1)), $urandom_range(99) < 80, tgt, meas, ticks);
  endtask

  // Registers only change with nothing in flight; a read request gives a
  // result too, so an empty queue plus a short settle means idle.
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [15:0] kp, logic [15:0] ki, logic [15:0] hi,
                           logic [15:0] lo, logic [15:0] tmax);
    wait_idle();
    write_cfg(REG_PROP_GAIN, kp);
    write_cfg(REG_INTEG_GAIN, ki);
    write_cfg(REG_DRIVE_MAX, hi);
    write_cfg(REG_DRIVE_MIN, lo);
    write_cfg(REG_MAX_TICKS, tmax);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    no_idle = 1'b0; requests_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reads of reset state, updates with field extremes, both channels.
    send_request(0, 0, 16'h0000, 16'h0000, 16'd0);
    send_request(1, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(0, 1, 16'h0100, 16'h0000, 16'd10);
    send_request(1, 1, 16'h7FFF, 16'h8000, 16'hFFFF);  // max error, ticks capped
    send_request(1, 1, 16'h8000, 16'h7FFF, 16'hFFFF);  // min error
    send_request(0, 1, 16'h8000, 16'h7FFF, 16'd0);     // zero ticks
    send_request(0, 0, 16'h1234, 16'h4321, 16'd5);
    send_request(1, 0, 16'h0000, 16'h0000, 16'd0);

    // Extreme gains, wide limits, no tick cap: drive the output into its clamp.
    write_all(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
    for (int i = 0; i < 6; i++) send_request(i[0], 1, 16'h7FFF, 16'h8000, 16'hFFFF);
    write_all(16'd0, 16'd1, 16'h7FFF, 16'h8000, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_request(0, 1, 16'h8000, 16'h7FFF, 16'hFFFF);

    // Crossed limits and zero gains / zero tick cap.
    write_all(16'd0, 16'd0, 16'hF000, 16'h1000, 16'd0);
    send_request(0, 1, 16'h0100, 16'h0000, 16'd50);
    send_request(1, 0, 16'h0, 16'h0, 16'd0);
    write_all(16'd4915, 16'd53687, 16'd16384, 16'hCCCD, 16'd1000);

    // Random phases with varied settings; one phase runs without bubbles.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        if (ph % 3 == 0)
          write_all(16'd4915, 16'd53687, 16'd16384, 16'hCCCD, 16'd1000);
        else
          write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 32767)),
                    16'(-$urandom_range(0, 32768)), 16'($urandom));
      end
      no_idle = (ph == 4);
      for (int i = 0; i < 150; i++) send_random();
    end
    no_idle = 1'b0;

    wait_idle();
    $display("Covered %0d requests, %0d updates, %0d clamped drives, %0d results checked.",
             requests_sent, sb.updates, sb.clamps, sb.checked);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
